// ----- hdl/ecc_pkg.sv -----
`timescale 1ns / 1ps
// ecc_pkg: constants and phase codes for the elevator collective controller
// no dependencies; imported by elevator_collective_controller

package ecc_pkg;

    // shaft geometry
    localparam int FLOORS  = 5;
    localparam int FLOOR_W = 3;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int PHASE_W = 2;
    localparam int TIMER_W = 16;
    localparam int PERS_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // input item kinds
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_BTN   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ENTER = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LEAVE = 2'd3;

    // car phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CLOSING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_MOVING  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_OPENING = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP   = 2'd2;

    // register reset values
    localparam logic [TIMER_W-1:0] DOOR_TICKS_RST   = 16'd10;
    localparam logic [TIMER_W-1:0] TRAVEL_TICKS_RST = 16'd50;
    localparam logic [PERS_W-1:0]  CROWD_LIM_RST    = 4'd4;
    localparam logic [PERS_W-1:0]  PERS_MAX         = 4'd15;

endpackage

// ----- hdl/elevator_collective_controller.sv -----
`timescale 1ns / 1ps
// elevator_collective_controller: scan-order elevator car controller, one result per beat
// depends on ecc_pkg for phase codes, widths and register reset values

// Five-floor elevator controller with up/down collective (scan) service. Every input
// beat is a tick, a floor button press, a person entering or a person leaving
// (s_axis_tuser), and every input beat yields exactly one output beat that carries
// the car state after that event has been applied. Unless the output stalls, a beat
// is taken in every cycle: it lands in an input register, the next state is worked out
// by shallow logic and written together with the output register, so the output
// beat follows its input handshake through these two registers and the sustained
// rate is one beat per clock, limited only by the output side draining. Back-pressure
// on the output stalls the input register, which then stalls s_axis_tready. Only ticks
// advance the door and travel timers; door_ticks and travel_ticks of zero act as one.
// The passenger count saturates at 0 and 15 and changes only while the door is open.
// Configuration writes (door_ticks, travel_ticks, crowd limit) take effect at once
// and are expected only while no beat is in flight.

module elevator_collective_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [ecc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ecc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ecc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [2:0] floor_sel, rest zero
    input  logic [ecc_pkg::FUNC_W-1:0]           s_axis_tuser,  // [1:0] func
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] floor_now, [3] down_dir, [4] door_open, [5] car_moving,
    // [6] overloaded, [11:7] pending, [13:12] phase_now, [15:14] zero
    output logic [ecc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import ecc_pkg::*;

    // configuration registers
    logic [TIMER_W-1:0] r_door_ticks;
    logic [TIMER_W-1:0] r_travel_ticks;
    logic [PERS_W-1:0]  r_crowd_lim;

    // input register
    logic               r_in_valid;
    logic [FUNC_W-1:0]  r_func;
    logic [FLOOR_W-1:0] r_sel;

    // car state
    logic [FLOORS-1:0]  r_req,    n_req;
    logic [FLOOR_W-1:0] r_floor,  n_floor;
    logic               r_down,   n_down;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [TIMER_W-1:0] r_timer,  n_timer;
    logic [PERS_W-1:0]  r_pers,   n_pers;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic               advance;
    logic [FLOORS-1:0]  below_mask;
    logic [FLOORS-1:0]  ahead;
    logic [FLOORS-1:0]  behind;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] door_lim;
    logic [TIMER_W-1:0] travel_lim;
    logic               door_done;
    logic               travel_done;
    logic               at_top;
    logic               at_ground;
    logic [FLOOR_W-1:0] step_floor;

    // the compute stage fires when the output register is free or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // requests split around the car position
    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            below_mask[i] = (FLOOR_W'(i) < r_floor);
        end
    end

    assign ahead  = r_down ? (r_req & below_mask) : (r_req & ~below_mask);
    assign behind = r_down ? (r_req & ~below_mask) : (r_req & below_mask);

    // shared phase timer; a zero limit counts as one
    assign timer_inc   = r_timer + TIMER_W'(1);
    assign door_lim    = (r_door_ticks == '0) ? TIMER_W'(1) : r_door_ticks;
    assign travel_lim  = (r_travel_ticks == '0) ? TIMER_W'(1) : r_travel_ticks;
    assign door_done   = (timer_inc >= door_lim);
    assign travel_done = (timer_inc >= travel_lim);

    assign at_top     = (r_floor >= FLOOR_W'(FLOORS - 1));
    assign at_ground  = (r_floor == '0);
    assign step_floor = r_down ? (r_floor - FLOOR_W'(1)) : (r_floor + FLOOR_W'(1));

    // next state for the item held in the input register
    always_comb begin
        n_req   = r_req;
        n_floor = r_floor;
        n_down  = r_down;
        n_phase = r_phase;
        n_timer = r_timer;
        n_pers  = r_pers;

        unique case (r_func)
            FN_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (ahead != '0) begin
                            n_phase = PH_CLOSING;
                            n_timer = '0;
                        end else if (behind != '0) begin
                            n_down = !r_down;
                        end
                    end
                    PH_CLOSING: begin
                        n_timer = timer_inc;
                        if (door_done) begin
                            n_timer = '0;
                            // served on the spot: reopen without moving
                            if (r_req[r_floor]) begin
                                n_req[r_floor] = 1'b0;
                                n_phase        = PH_OPENING;
                            end else begin
                                n_phase = PH_MOVING;
                            end
                        end
                    end
                    PH_MOVING: begin
                        n_timer = timer_inc;
                        if (travel_done) begin
                            n_timer = '0;
                            if (r_down ? at_ground : at_top) begin
                                // end of shaft: stop where the car is
                                n_req[r_floor] = 1'b0;
                                n_phase        = PH_OPENING;
                            end else begin
                                n_floor = step_floor;
                                if (r_req[step_floor]) begin
                                    n_req[step_floor] = 1'b0;
                                    n_phase           = PH_OPENING;
                                end
                            end
                        end
                    end
                    PH_OPENING: begin
                        n_timer = timer_inc;
                        if (door_done) begin
                            n_timer = '0;
                            n_phase = PH_IDLE;
                            // turn around at either end of the shaft
                            if (!r_down && at_top) begin
                                n_down = 1'b1;
                            end else if (r_down && at_ground) begin
                                n_down = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            FN_BTN: begin
                if (r_sel < FLOOR_W'(FLOORS)) begin
                    n_req[r_sel] = 1'b1;
                end
            end
            FN_ENTER: begin
                if (r_phase == PH_IDLE && r_pers != PERS_MAX) begin
                    n_pers = r_pers + PERS_W'(1);
                end
            end
            FN_LEAVE: begin
                if (r_phase == PH_IDLE && r_pers != '0) begin
                    n_pers = r_pers - PERS_W'(1);
                end
            end
            default: begin
                n_pers = r_pers;
            end
        endcase

        n_out_data = {2'b00,
                      n_phase,
                      n_req,
                      (n_pers > r_crowd_lim),
                      (n_phase == PH_MOVING),
                      (n_phase == PH_IDLE),
                      n_down,
                      n_floor};
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_ticks   <= DOOR_TICKS_RST;
            r_travel_ticks <= TRAVEL_TICKS_RST;
            r_crowd_lim    <= CROWD_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DOOR:   r_door_ticks   <= i_cfg_data;
                CFG_TRAVEL: r_travel_ticks <= i_cfg_data;
                CFG_MAXP:   r_crowd_lim    <= i_cfg_data[PERS_W-1:0];
                default:    r_crowd_lim    <= r_crowd_lim;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func <= s_axis_tuser;
            r_sel  <= s_axis_tdata[FLOOR_W-1:0];
        end
    end

    // car state and output register update together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_floor     <= '0;
            r_down      <= 1'b0;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_pers      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_req   <= n_req;
                r_floor <= n_floor;
                r_down  <= n_down;
                r_phase <= n_phase;
                r_timer <= n_timer;
                r_pers  <= n_pers;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
